/* design/cartesian_to_spherical_core_macros.svh */
// assertion shorthands used by the checker of this block
`ifndef CARTESIAN_TO_SPHERICAL_CORE_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define C2S_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cartesian_to_spherical_core check failed");

// next-cycle implication, sampled on clk, off during reset
`define C2S_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cartesian_to_spherical_core check failed");

`endif

/* design/c2s_pkg.sv */
package c2s_pkg;

    // internal datapath and angle accumulator widths
    localparam int DP_W  = 64;
    localparam int ANG_W = 36;

    localparam logic signed [ANG_W-1:0] PI_Q32 = 36'sd13493037705;
    localparam logic [29:0]             THETA_PI = 30'd843314857;
    localparam logic signed [30:0]      AZ_PI    = 31'sd843314857;

    typedef struct packed {
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ANG_W-1:0] a;
        logic                    zero_y;
        logic                    left;
    } cordic_t;

    // arctangent of 2^-i in q32 radians
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] r;
        r = '0;
        case (i)
            0:  r = 36'sd3373259426;
            1:  r = 36'sd1991351318;
            2:  r = 36'sd1073650183;
            3:  r = 36'sd534100635;
            4:  r = 36'sd268086748;
            5:  r = 36'sd134174063;
            6:  r = 36'sd67103403;
            7:  r = 36'sd33553749;
            8:  r = 36'sd16777131;
            9:  r = 36'sd8388597;
            10: r = 36'sd4194303;
            default:
            begin
                if (i <= 32)
                    r = ANG_W'(64'sd1 <<< (32 - i));
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

    // q32 reciprocal of the cordic gain for n iterations
    function automatic logic [31:0] gain_inverse(input int n);
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        logic [63:0] sq;
        p = 64'd1 << 62;
        q = '0;
        for (int i = 0; i < n; i++)
        begin
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        end
        for (int b = 31; b >= 0; b--)
        begin
            t  = q | (64'd1 << b);
            sq = t * t;
            if ((sq >> 34) * (p >> 32) <= (64'd1 << 60))
                q = t;
        end
        return q[31:0];
    endfunction

endpackage

/* design/c2s_cordic_stage.sv */
module c2s_cordic_stage
    import c2s_pkg::*;
#(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cordic_t           in_data,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output cordic_t           out_data,
    output logic [SIDE_W-1:0] out_side
);

    localparam logic signed [ANG_W-1:0] STEP = atan_step(SHIFT);

    logic              valid_reg;
    cordic_t           data_reg;
    cordic_t           data_next;
    logic [SIDE_W-1:0] side_reg;

    // one micro-rotation toward the x axis
    always_comb
    begin
        data_next = in_data;
        if (!in_data.y[DP_W-1])
        begin
            data_next.x = in_data.x + (in_data.y >>> SHIFT);
            data_next.y = in_data.y - (in_data.x >>> SHIFT);
            data_next.a = in_data.a + STEP;
        end
        else
        begin
            data_next.x = in_data.x - (in_data.y >>> SHIFT);
            data_next.y = in_data.y + (in_data.x >>> SHIFT);
            data_next.a = in_data.a - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

/* design/c2s_vector_pass.sv */
module c2s_vector_pass
    import c2s_pkg::*;
#(
    parameter int STAGES = 30,
    parameter int SIDE_W = 1
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DP_W-1:0]  x_in,
    input  logic signed [DP_W-1:0]  y_in,
    input  logic [SIDE_W-1:0]       in_side,
    output logic                    out_valid,
    output logic signed [DP_W-1:0]  mag,
    output logic signed [ANG_W-1:0] ang,
    output logic [SIDE_W-1:0]       out_side
);

    logic              prep_valid_reg;
    cordic_t           prep_reg;
    cordic_t           prep_next;
    logic [SIDE_W-1:0] prep_side_reg;

    logic              chain_valid [STAGES+1];
    cordic_t           chain_data  [STAGES+1];
    logic [SIDE_W-1:0] chain_side  [STAGES+1];

    // fold the left half plane onto the right one
    always_comb
    begin
        prep_next.zero_y = (y_in == '0);
        prep_next.left   = x_in[DP_W-1];
        prep_next.x      = x_in;
        prep_next.y      = y_in;
        prep_next.a      = '0;
        if (x_in[DP_W-1])
        begin
            prep_next.x = -x_in;
            prep_next.y = -y_in;
            prep_next.a = y_in[DP_W-1] ? -PI_Q32 : PI_Q32;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_reg      <= prep_next;
            prep_side_reg <= in_side;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_data[0]  = prep_reg;
    assign chain_side[0]  = prep_side_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        c2s_cordic_stage #(
            .SHIFT  (i),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // a zero second operand gives an exact angle
    always_comb
    begin
        ang = chain_data[STAGES].a;
        if (chain_data[STAGES].zero_y)
            ang = chain_data[STAGES].left ? PI_Q32 : '0;
    end

    assign out_valid = chain_valid[STAGES];
    assign mag       = chain_data[STAGES].x;
    assign out_side  = chain_side[STAGES];

endmodule

/* design/c2s_gain_mul.sv */
module c2s_gain_mul
    import c2s_pkg::*;
#(
    parameter logic [31:0] GAIN_Q = 32'd0,
    parameter int          SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DP_W-1:0]   mag,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DP_W-1:0]   prod,
    output logic [SIDE_W-1:0] out_side
);

    logic [1:0]        valid_reg;
    logic [DP_W-1:0]   hi_reg;
    logic [DP_W-1:0]   lo_reg;
    logic [DP_W-1:0]   prod_reg;
    logic [SIDE_W-1:0] side_a_reg;
    logic [SIDE_W-1:0] side_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[0], in_valid};
    end

    // partial products, then their sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg     <= DP_W'(mag[63:32]) * DP_W'(GAIN_Q);
            lo_reg     <= DP_W'(mag[31:0]) * DP_W'(GAIN_Q);
            side_a_reg <= in_side;
            prod_reg   <= hi_reg + {32'd0, lo_reg[63:32]};
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = valid_reg[1];
    assign prod      = prod_reg;
    assign out_side  = side_b_reg;

endmodule

/* design/cartesian_to_spherical_core.sv */
// Converts a stream of points (x, y, z, signed Q16.16) into radius (unsigned
// Q16.16), polar angle theta in [0, pi] (unsigned Q2.28 radians) and azimuth
// phi in [-pi, pi] (signed Q3.28 radians), one point per clock while in_stall
// is low. Two chains of CORDIC_STAGES unrolled vectoring stages do the work:
// the first turns (x, y) into the planar radius and phi, the second turns
// (z, planar radius) into r and theta; each chain is followed by a two-stage
// gain-correction multiply. An output register plus one skid entry keep the
// pipeline flowing while a result waits; in_stall rises only once the skid
// entry is full. The origin gives r = 0 and both angles 0.
module cartesian_to_spherical_core
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 30
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic signed [COORD_WIDTH-1:0] z_coord,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COORD_WIDTH-1:0]        radius,
    output logic [29:0]                   polar_angle,
    output logic signed [30:0]            azimuth,
    output logic                          last_out
);

    // guard bits so every coordinate width lands at the same scale
    localparam int          GUARD  = 58 - COORD_WIDTH;
    localparam logic [31:0] GAIN_Q = gain_inverse(CORDIC_STAGES);

    localparam int P1_SIDE = DP_W + 1;
    localparam int M1_SIDE = DP_W + 1 + 31;
    localparam int P2_SIDE = 1 + 31;
    localparam int M2_SIDE = 1 + 31 + 30;

    // q32 angle to q28 with round half up
    function automatic logic signed [32:0] round_q28(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W:0] s;
        s = {a[ANG_W-1], a} + 37'sd8;
        return s[ANG_W:4];
    endfunction

    // whole pipeline moves together unless the skid entry is occupied
    logic en;

    // first pass: (x, y)
    logic                    p1_valid;
    logic signed [DP_W-1:0]  p1_mag;
    logic signed [ANG_W-1:0] p1_ang;
    logic [P1_SIDE-1:0]      p1_side;
    logic signed [32:0]      phi_round;
    logic signed [30:0]      phi_clamped;

    // gain correction for the planar radius
    logic                    m1_valid;
    logic [DP_W-1:0]         rho;
    logic [M1_SIDE-1:0]      m1_side;

    // second pass: (z, rho)
    logic                    p2_valid;
    logic signed [DP_W-1:0]  p2_mag;
    logic signed [ANG_W-1:0] p2_ang;
    logic [P2_SIDE-1:0]      p2_side;
    logic signed [32:0]      theta_round;
    logic [29:0]             theta_clamped;

    logic                    m2_valid;
    logic [DP_W-1:0]         r_full;
    logic [M2_SIDE-1:0]      m2_side;

    // final rounding of the radius
    logic [DP_W:0]           r_sum;
    logic [DP_W:0]           r_shift;
    logic [COORD_WIDTH-1:0]  r_sat;

    // result stage, output register, skid entry
    logic                    res_valid_reg;
    logic [COORD_WIDTH-1:0]  res_radius_reg;
    logic [29:0]             res_theta_reg;
    logic signed [30:0]      res_phi_reg;
    logic                    res_last_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [COORD_WIDTH-1:0]  out_radius_reg;
    logic [29:0]             out_theta_reg;
    logic signed [30:0]      out_phi_reg;
    logic                    out_last_reg;
    logic                    out_load_res;
    logic                    out_load_skid;

    logic                    skid_full_reg;
    logic                    skid_full_next;
    logic                    skid_load;
    logic [COORD_WIDTH-1:0]  skid_radius_reg;
    logic [29:0]             skid_theta_reg;
    logic signed [30:0]      skid_phi_reg;
    logic                    skid_last_reg;

    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // coordinates scaled up by the guard bits; z and the batch mark ride along
    c2s_vector_pass #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (P1_SIDE)
    ) u_pass_xy (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .x_in      (DP_W'(x_coord) <<< GUARD),
        .y_in      (DP_W'(y_coord) <<< GUARD),
        .in_side   ({DP_W'(z_coord) <<< GUARD, last_point}),
        .out_valid (p1_valid),
        .mag       (p1_mag),
        .ang       (p1_ang),
        .out_side  (p1_side)
    );

    // phi is final after the first pass: round and clamp to [-pi, pi]
    always_comb
    begin
        phi_round = round_q28(p1_ang);
        if (phi_round < -33'(AZ_PI))
            phi_clamped = -AZ_PI;
        else if (phi_round > 33'(AZ_PI))
            phi_clamped = AZ_PI;
        else
            phi_clamped = phi_round[30:0];
    end

    c2s_gain_mul #(
        .GAIN_Q (GAIN_Q),
        .SIDE_W (M1_SIDE)
    ) u_gain_rho (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p1_valid),
        .mag       (p1_mag),
        .in_side   ({p1_side, phi_clamped}),
        .out_valid (m1_valid),
        .prod      (rho),
        .out_side  (m1_side)
    );

    // second pass takes z as x and the planar radius as y
    c2s_vector_pass #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (P2_SIDE)
    ) u_pass_zr (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m1_valid),
        .x_in      (m1_side[M1_SIDE-1:32]),
        .y_in      (rho),
        .in_side   (m1_side[31:0]),
        .out_valid (p2_valid),
        .mag       (p2_mag),
        .ang       (p2_ang),
        .out_side  (p2_side)
    );

    // theta clamped to [0, pi]
    always_comb
    begin
        theta_round = round_q28(p2_ang);
        if (theta_round[32])
            theta_clamped = '0;
        else if (theta_round > 33'(THETA_PI))
            theta_clamped = THETA_PI;
        else
            theta_clamped = theta_round[29:0];
    end

    c2s_gain_mul #(
        .GAIN_Q (GAIN_Q),
        .SIDE_W (M2_SIDE)
    ) u_gain_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid),
        .mag       (p2_mag),
        .in_side   ({p2_side, theta_clamped}),
        .out_valid (m2_valid),
        .prod      (r_full),
        .out_side  (m2_side)
    );

    // drop the guard bits with rounding, saturate at full scale
    always_comb
    begin
        r_sum   = {1'b0, r_full} + ((DP_W+1)'(1) << (GUARD - 1));
        r_shift = r_sum >> GUARD;
        if (r_shift[DP_W:COORD_WIDTH] != '0)
            r_sat = '1;
        else
            r_sat = r_shift[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= m2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_radius_reg <= r_sat;
            res_theta_reg  <= m2_side[29:0];
            res_phi_reg    <= m2_side[60:30];
            res_last_reg   <= m2_side[61];
        end
    end

    // a result leaving the pipeline goes straight out if the output slot
    // frees this cycle, otherwise into the skid entry, which freezes the pipe
    always_comb
    begin
        out_load_res   = 1'b0;
        out_load_skid  = 1'b0;
        skid_load      = 1'b0;
        out_valid_next = out_valid_reg;
        skid_full_next = skid_full_reg;
        if (en && res_valid_reg)
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_load_res   = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_load      = 1'b1;
                skid_full_next = 1'b1;
            end
        end
        else if (skid_full_reg)
        begin
            if (!out_stall)
            begin
                out_load_skid  = 1'b1;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_res)
        begin
            out_radius_reg <= res_radius_reg;
            out_theta_reg  <= res_theta_reg;
            out_phi_reg    <= res_phi_reg;
            out_last_reg   <= res_last_reg;
        end
        else if (out_load_skid)
        begin
            out_radius_reg <= skid_radius_reg;
            out_theta_reg  <= skid_theta_reg;
            out_phi_reg    <= skid_phi_reg;
            out_last_reg   <= skid_last_reg;
        end
        if (skid_load)
        begin
            skid_radius_reg <= res_radius_reg;
            skid_theta_reg  <= res_theta_reg;
            skid_phi_reg    <= res_phi_reg;
            skid_last_reg   <= res_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign radius      = out_radius_reg;
    assign polar_angle = out_theta_reg;
    assign azimuth     = out_phi_reg;
    assign last_out    = out_last_reg;

endmodule

/* design/c2s_checker.sv */
`include "cartesian_to_spherical_core_macros.svh"

module c2s_checker
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [COORD_WIDTH-1:0]        radius,
    input logic [29:0]                   polar_angle,
    input logic signed [30:0]            azimuth
);

    // a held result keeps its payload
    `C2S_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(radius) && $stable(azimuth) && $stable(polar_angle))

    // the input only backs up behind a waiting result
    `C2S_ASSERT_IMP(a_stall_cause, in_stall, out_valid)

    // angles stay inside their ranges
    `C2S_ASSERT_IMP(a_theta_range, out_valid, polar_angle <= THETA_PI)
    `C2S_ASSERT_IMP(a_phi_range, out_valid, (azimuth >= -AZ_PI) && (azimuth <= AZ_PI))

endmodule

bind cartesian_to_spherical_core c2s_checker #(.COORD_WIDTH(COORD_WIDTH)) u_c2s_checker (.*);

/* tb/spherical_result_checker.sv */
`timescale 1ns / 100ps

module spherical_result_checker
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 30
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic signed [COORD_WIDTH-1:0] z_coord,
    input  logic                          last_point,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [COORD_WIDTH-1:0]        radius,
    input  logic [29:0]                   polar_angle,
    input  logic signed [30:0]            azimuth,
    input  logic                          last_out,
    output int                            mismatch_count,
    output int                            points_in_flight
);

    localparam int GUARD = 58 - COORD_WIDTH;
    localparam logic signed [63:0] HALF_TURN_Q32 = 64'sd13493037705;
    localparam logic signed [63:0] HALF_TURN_Q28 = 64'sd843314857;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] r;
        logic [29:0]            theta;
        logic signed [30:0]     phi;
        logic                   last;
    } spherical_t;

    spherical_t expected_points[$];
    logic [63:0] inv_gain;

    function automatic logic signed [63:0] arctan_q32(input int i);
        logic signed [63:0] head [0:10];
        head = '{64'sd3373259426, 64'sd1991351318, 64'sd1073650183, 64'sd534100635,
                 64'sd268086748, 64'sd134174063, 64'sd67103403, 64'sd33553749,
                 64'sd16777131, 64'sd8388597, 64'sd4194303};
        if (i < 11)
            return head[i];
        if (i <= 32)
            return 64'sd1 <<< (32 - i);
        return 64'sd0;
    endfunction

    function automatic logic [63:0] compute_inv_gain();
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] t;
        p = 64'd1 << 62;
        q = '0;
        for (int i = 0; i < CORDIC_STAGES; i++)
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        for (int b = 31; b >= 0; b--)
        begin
            t = q | (64'd1 << b);
            if (((t * t) >> 34) * (p >> 32) <= (64'd1 << 60))
                q = t;
        end
        return q;
    endfunction

    function automatic logic [63:0] remove_gain(input logic [63:0] v, input logic [63:0] q);
        return (v >> 32) * q + (((v & 64'hFFFF_FFFF) * q) >> 32);
    endfunction

    // rotate (xi, yi) onto the positive x axis, collecting the angle in q32
    function automatic void rotate_to_axis(input logic signed [63:0] xi,
                                           input logic signed [63:0] yi,
                                           output logic signed [63:0] mag,
                                           output logic signed [63:0] ang);
        logic signed [63:0] xv;
        logic signed [63:0] yv;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic               on_axis;
        logic               left_half;
        xv = xi;
        yv = yi;
        ang = 0;
        on_axis = (yi == 0);
        left_half = (xi < 0);
        if (left_half)
        begin
            ang = (yv >= 0) ? HALF_TURN_Q32 : -HALF_TURN_Q32;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0)
            begin
                xv = xv + dx;
                yv = yv - dy;
                ang = ang + arctan_q32(i);
            end
            else
            begin
                xv = xv - dx;
                yv = yv + dy;
                ang = ang - arctan_q32(i);
            end
        end
        if (on_axis)
            ang = left_half ? HALF_TURN_Q32 : 64'sd0;
        mag = xv;
    endfunction

    function automatic logic signed [63:0] round_angle(input logic signed [63:0] a,
                                                       input logic signed [63:0] lo,
                                                       input logic signed [63:0] hi);
        logic signed [63:0] v;
        v = (a + 8) >>> 4;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        return v;
    endfunction

    function automatic spherical_t predict_spherical(input logic signed [COORD_WIDTH-1:0] xc,
                                                     input logic signed [COORD_WIDTH-1:0] yc,
                                                     input logic signed [COORD_WIDTH-1:0] zc,
                                                     input logic lp);
        logic signed [63:0] mag1;
        logic signed [63:0] phi32;
        logic signed [63:0] mag2;
        logic signed [63:0] theta32;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] sz;
        logic [63:0]        rho;
        logic [63:0]        rv;
        logic [63:0]        rmax;
        logic signed [63:0] th;
        logic signed [63:0] ph;
        spherical_t         res;
        sx = 64'(xc) <<< GUARD;
        sy = 64'(yc) <<< GUARD;
        sz = 64'(zc) <<< GUARD;
        rotate_to_axis(sx, sy, mag1, phi32);
        rho = remove_gain(mag1, inv_gain);
        rotate_to_axis(sz, rho, mag2, theta32);
        rv = remove_gain(mag2, inv_gain);
        rv = (rv + (64'd1 << (GUARD - 1))) >> GUARD;
        rmax = (64'd1 << COORD_WIDTH) - 1;
        if (rv > rmax)
            rv = rmax;
        th = round_angle(theta32, 64'sd0, HALF_TURN_Q28);
        ph = round_angle(phi32, -HALF_TURN_Q28, HALF_TURN_Q28);
        res.r = rv[COORD_WIDTH-1:0];
        res.theta = th[29:0];
        res.phi = ph[30:0];
        res.last = lp;
        return res;
    endfunction

    initial
        inv_gain = compute_inv_gain();

    assign points_in_flight = expected_points.size();

    always @(posedge clk)
    begin
        spherical_t want;
        if (rst_n)
        begin
            // input transfer: queue the expected result
            if (in_valid && !in_stall)
                expected_points.push_back(predict_spherical(x_coord, y_coord, z_coord,
                                                            last_point));
            // output transfer: compare against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result r=%0h theta=%0h phi=%0h last=%0b",
                                 radius, polar_angle, azimuth, last_out);
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (want.r !== radius || want.theta !== polar_angle ||
                        want.phi !== azimuth || want.last !== last_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch exp r=%0h theta=%0h phi=%0h last=%0b,",
                                     want.r, want.theta, want.phi, want.last,
                                     " got r=%0h theta=%0h phi=%0h last=%0b",
                                     radius, polar_angle, azimuth, last_out);
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_cartesian_to_spherical_core.sv */
`timescale 1ns / 100ps

module tb_cartesian_to_spherical_core;

    localparam int W          = 32;
    localparam int STAGES     = 30;
    localparam int LATENCY    = 2 * STAGES + 8;
    localparam int CYCLE_CAP  = 300000;
    localparam int RANDOM_PTS = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [W-1:0]  x_coord;
    logic signed [W-1:0]  y_coord;
    logic signed [W-1:0]  z_coord;
    logic                 last_point;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [W-1:0]         radius;
    logic [29:0]          polar_angle;
    logic signed [30:0]   azimuth;
    logic                 last_out;
    int                   mismatch_count;
    int                   points_in_flight;
    int                   cycle_count;
    int                   stall_mode;
    int                   stall_left;

    cartesian_to_spherical_core #(
        .COORD_WIDTH(W),
        .CORDIC_STAGES(STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .z_coord(z_coord),
        .last_point(last_point),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .radius(radius),
        .polar_angle(polar_angle),
        .azimuth(azimuth),
        .last_out(last_out)
    );

    // watches both channels, predicts each point and compares the results
    spherical_result_checker #(
        .COORD_WIDTH(W),
        .CORDIC_STAGES(STAGES)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .z_coord(z_coord),
        .last_point(last_point),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .radius(radius),
        .polar_angle(polar_angle),
        .azimuth(azimuth),
        .last_out(last_out),
        .mismatch_count(mismatch_count),
        .points_in_flight(points_in_flight)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // run limit, generous against the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("cartesian_to_spherical_core test failed");
            $finish;
        end
    end

    // receiver back-pressure in stretches: none, light, heavy, or long holds
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 150);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 2);
            2: out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= ($urandom_range(0, 99) < 3) ? 1'b1
                                  : (out_stall && $urandom_range(0, 9) < 9);
        endcase
    end

    // one input transfer; valid stays up if the next point follows at once
    task automatic send_point(input logic signed [W-1:0] xv, input logic signed [W-1:0] yv,
                              input logic signed [W-1:0] zv, input logic lp);
        logic taken;
        in_valid <= 1'b1;
        x_coord <= xv;
        y_coord <= yv;
        z_coord <= zv;
        last_point <= lp;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
    endtask

    // idle the sender for a random gap, mostly none or short
    task automatic sender_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        len = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (len > 0)
        begin
            in_valid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // random coordinate: full range, small magnitude, zero or an extreme
    function automatic logic signed [W-1:0] pick_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return $urandom;
        if (pick < 75)
            return $signed($urandom_range(0, 2097151)) - 1048576;
        if (pick < 85)
            return '0;
        if (pick < 90)
            return {1'b1, {(W-1){1'b0}}};
        if (pick < 95)
            return {1'b0, {(W-1){1'b1}}};
        return $signed($urandom_range(0, 16)) - 8;
    endfunction

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = 32'sh0001_0000;

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_coord = '0;
        y_coord = '0;
        z_coord = '0;
        last_point = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: origin, axes, half planes, extremes
        send_point('0, '0, '0, 1'b0);
        send_point(ONE, '0, '0, 1'b0);
        send_point(-ONE, '0, '0, 1'b1);
        send_point('0, ONE, '0, 1'b0);
        send_point('0, -ONE, '0, 1'b0);
        send_point('0, '0, ONE, 1'b0);
        send_point('0, '0, -ONE, 1'b1);
        send_point(-ONE, ONE, ONE, 1'b0);
        send_point(-ONE, -ONE, -ONE, 1'b0);
        send_point(-ONE, 32'sd1, '0, 1'b0);
        send_point(-ONE, -32'sd1, '0, 1'b0);
        send_point(MAXV, MAXV, MAXV, 1'b0);
        send_point(MINV, MINV, MINV, 1'b1);
        send_point(MINV, '0, MAXV, 1'b0);
        send_point(MAXV, MINV, MINV, 1'b0);
        send_point(MINV, MAXV, '0, 1'b0);
        send_point(32'sd1, 32'sd1, 32'sd1, 1'b0);
        send_point(-32'sd1, '0, '0, 1'b0);
        send_point('0, '0, MINV, 1'b1);
        send_point('0, '0, MAXV, 1'b0);

        for (int n = 0; n < RANDOM_PTS; n++)
        begin
            // let the pipeline drain completely once, mid-run
            if (n == RANDOM_PTS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (points_in_flight != 0)
                    @(posedge clk);
            end
            sender_gap();
            send_point(pick_coord(), pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;

        while (points_in_flight != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatch_count == 0)
            $display("cartesian_to_spherical_core test passed");
        else
            $display("cartesian_to_spherical_core test failed");
        $finish;
    end

endmodule
